FILE: hw/rtl/tspsch_pkg.sv
package tspsch_pkg;

  // Default number of process slots in the table.
  localparam int unsigned TSPSCH_NUM_SLOTS = 16;

  // Field widths of the stream payloads.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned SLICE_W    = 9;
  localparam int unsigned TICKS_W    = 32;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  // Commands carried in the input tuser field.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESCHED = 2'd2
  } cmd_e;

  // One process slot entry.
  typedef struct packed {
    logic               runnable;
    logic [PRIO_W-1:0]  prio;
    logic [SLICE_W-1:0] slices;
    logic [TICKS_W-1:0] ticks;
  } entry_t;

  // Operation that a cell performs on its entry.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TICK,
    CELL_SHIFT,
    CELL_REFILL
  } cell_op_e;

  // Control bundle from the sequencer to each cell.
  typedef struct packed {
    cell_op_e op;
    entry_t   wr_entry;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/time_slice_process_scheduler_core.sv
// Time-slice process scheduler. The slot table lives in a ring of NUM_SLOTS
// cells, one slot per cell, cleared at reset. Each input transaction carries a
// command in tuser (clock tick, entry write or reschedule request) and returns
// exactly one result transaction with the current slot, its slices and run
// ticks. For a write, an unused command or a tick that leaves slices above zero
// the sequencer goes straight to its report state, which loads the registered
// result. A selection rotates the whole ring past a single compare stage at the
// head cell, one slot per cycle, then reports; when no runnable slot has slices
// the table is refilled and scanned a second time before the report. One
// transaction is in flight at a time; the next one is accepted at the same edge
// that takes the result, or later while the result side stalls.
module time_slice_process_scheduler_core import tspsch_pkg::*; #(
  parameter int unsigned NUM_SLOTS = TSPSCH_NUM_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot[3:0], runnable[4], prio_value[12:5], slice_value[21:13], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // cur_slot[3:0], switched[4], idle[5], cur_slices[14:6],
  // cur_run_ticks[46:15], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CMP_W = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REFILL,
    ST_REPORT
  } state_e;

  state_e                 state_q, state_d;
  logic [SW-1:0]          cnt_q, cnt_d;
  logic                   pass_q, pass_d;
  logic                   found_q, found_d;
  logic [SW-1:0]          best_q, best_d;
  logic [SLICE_W-1:0]     most_q, most_d;
  logic [SW-1:0]          cur_q, cur_d;
  logic                   sw_q, sw_d;
  logic                   idle_q, idle_d;
  logic                   m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0]  m_data_q, m_data_d;

  entry_t                 cell_entry [NUM_SLOTS];
  cell_ctrl_t             cell_ctrl  [NUM_SLOTS];

  // Input field unpacking.
  logic [SLOT_W-1:0]      in_slot;
  entry_t                 in_entry;
  logic                   in_accept;
  logic                   slot_ok;
  logic [SW-1:0]          wr_idx;
  entry_t                 cur_entry;
  entry_t                 head;
  logic                   head_hit;
  logic                   scan_last;

  assign in_slot          = s_axis_tdata[3:0];
  assign in_entry.runnable = s_axis_tdata[4];
  assign in_entry.prio     = s_axis_tdata[12:5];
  assign in_entry.slices   = s_axis_tdata[21:13];
  assign in_entry.ticks    = '0;

  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign slot_ok       = {3'b000, in_slot} < CMP_W'(NUM_SLOTS);
  assign wr_idx        = SW'(in_slot);
  assign cur_entry     = cell_entry[cur_q];
  assign head          = cell_entry[0];
  assign head_hit      = head.runnable && (head.slices > most_q);
  assign scan_last     = (cnt_q == SW'(NUM_SLOTS - 1));

  // Per-cell operation select.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cell_ctrl[i].op       = CELL_HOLD;
      cell_ctrl[i].wr_entry = in_entry;
      if (state_q == ST_SCAN) begin
        cell_ctrl[i].op = CELL_SHIFT;
      end else if (state_q == ST_REFILL) begin
        cell_ctrl[i].op = CELL_REFILL;
      end else if (in_accept) begin
        if (s_axis_tuser == CMD_WRITE && slot_ok && wr_idx == SW'(i)) begin
          cell_ctrl[i].op = CELL_LOAD;
        end else if (s_axis_tuser == CMD_TICK && cur_q == SW'(i)) begin
          cell_ctrl[i].op = CELL_TICK;
        end
      end
    end
  end

  // Ring of slot cells; each cell takes its successor's entry on a shift.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    localparam int unsigned NXT = (g + 1) % NUM_SLOTS;
    tspsch_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[g]),
      .next_i  (cell_entry[NXT]),
      .entry_o (cell_entry[g])
    );
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pass_d    = pass_q;
    found_d   = found_q;
    best_d    = best_q;
    most_d    = most_q;
    cur_d     = cur_q;
    sw_d      = sw_q;
    idle_d    = idle_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          sw_d    = 1'b0;
          idle_d  = 1'b0;
          cnt_d   = '0;
          pass_d  = 1'b0;
          found_d = 1'b0;
          best_d  = '0;
          most_d  = '0;
          // A tick reschedules when it leaves the slot without slices.
          if ((s_axis_tuser == CMD_TICK && cur_entry.slices <= SLICE_W'(1)) ||
              s_axis_tuser == CMD_RESCHED) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_REPORT;
          end
        end
      end
      ST_SCAN: begin
        // The head cell holds slot cnt_q; a strictly larger count wins.
        if (head_hit) begin
          found_d = 1'b1;
          best_d  = cnt_q;
          most_d  = head.slices;
        end
        cnt_d = cnt_q + SW'(1);
        if (scan_last) begin
          cnt_d = '0;
          if (found_q || head_hit) begin
            cur_d   = head_hit ? cnt_q : best_q;
            sw_d    = (head_hit ? cnt_q : best_q) != cur_q;
            idle_d  = 1'b0;
            state_d = ST_REPORT;
          end else if (!pass_q) begin
            pass_d  = 1'b1;
            state_d = ST_REFILL;
          end else begin
            sw_d    = 1'b0;
            idle_d  = 1'b1;
            state_d = ST_REPORT;
          end
        end
      end
      ST_REFILL: begin
        state_d = ST_SCAN;
      end
      ST_REPORT: begin
        m_valid_d = 1'b1;
        m_data_d  = {1'b0, cur_entry.ticks, cur_entry.slices, idle_q, sw_q, 4'(cur_q)};
        state_d   = ST_IDLE;
      end
    endcase
  end

  // Sequencer state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pass_q    <= 1'b0;
      found_q   <= 1'b0;
      best_q    <= '0;
      most_q    <= '0;
      cur_q     <= '0;
      sw_q      <= 1'b0;
      idle_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pass_q    <= pass_d;
      found_q   <= found_d;
      best_q    <= best_d;
      most_q    <= most_d;
      cur_q     <= cur_d;
      sw_q      <= sw_d;
      idle_q    <= idle_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: hw/rtl/tspsch_cell.sv
module tspsch_cell import tspsch_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     next_i,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // Next value of the slot entry held by this cell.
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_LOAD: begin
        entry_d = ctrl_i.wr_entry;
      end
      CELL_TICK: begin
        entry_d.ticks = entry_q.ticks + TICKS_W'(1);
        if (entry_q.slices != '0) begin
          entry_d.slices = entry_q.slices - SLICE_W'(1);
        end
      end
      CELL_SHIFT: begin
        entry_d = next_i;
      end
      CELL_REFILL: begin
        // Half the remaining slices plus the priority; at most 510, no overflow.
        entry_d.slices = {1'b0, entry_q.slices[SLICE_W-1:1]} + SLICE_W'(entry_q.prio);
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: hw/rtl/tspsch_checker.sv
module tspsch_checker import tspsch_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [CMD_W-1:0]      s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A new transaction is taken only when the result register can hold its result.
  a_room_for_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input accepted while a stalled result is pending");

  // Only one transaction is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted transaction");

  // An entry write produces its result through the report state, without a switch or idle.
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_WRITE) |->
      ##2 (m_axis_tvalid && !m_axis_tdata[4] && !m_axis_tdata[5]))
    else $error("entry write result missing or flagged");

  // A stalled result holds its payload.
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind time_slice_process_scheduler_core tspsch_checker u_tspsch_checker (.*);
